// ===== hdl/kmd_pkg.sv =====
// ---------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the key matrix scanner with debounce.
// ---------------------------------------------------------------------------
package kmd_pkg;

	localparam int CNT_W = 4;

	typedef logic [CNT_W-1:0] cnt_t;

	// debounce limit after reset
	localparam cnt_t LIMIT_RST = cnt_t'(3);

	// next state and events of one key for the current tick
	typedef struct packed {
		cnt_t cnt;
		logic led;
		logic press_ev;
		logic release_ev;
	} kmd_cell_t;

endpackage

// ===== hdl/kmd_if.sv =====
// ---------------------------------------------------------------------------
// kmd_if
// Valid/ready channels of the key matrix scanner: row sample in, result out.
// ---------------------------------------------------------------------------
interface kmd_in_if #(
	parameter int ROWS = 4
) ();
	logic            valid;
	logic            ready;
	logic [ROWS-1:0] row_levels;

	modport source (output valid, output row_levels, input ready);
	modport sink   (input valid, input row_levels, output ready);
endinterface

interface kmd_out_if #(
	parameter int ROWS  = 4,
	parameter int COL_W = 2
) ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column;
	logic [ROWS-1:0]  led_rows;
	logic [ROWS-1:0]  press_events;
	logic [ROWS-1:0]  release_events;

	modport source (output valid, output column, output led_rows, output press_events,
		output release_events, input ready);
	modport sink   (input valid, input column, input led_rows, input press_events,
		input release_events, output ready);
endinterface

// ===== hdl/kmd_cell.sv =====
// ---------------------------------------------------------------------------
// kmd_cell
// Integrating debounce of one key: counter step, press/release events and
// LED toggle.
// ---------------------------------------------------------------------------
module kmd_cell (
	input  logic             level,
	input  kmd_pkg::cnt_t    cnt,
	input  kmd_pkg::cnt_t    limit,
	input  logic             led,
	output kmd_pkg::kmd_cell_t nxt
);
	import kmd_pkg::*;

	cnt_t cnt_inc;
	cnt_t cnt_dec;

	assign cnt_inc = cnt + cnt_t'(1);
	assign cnt_dec = cnt - cnt_t'(1);

	always_comb begin
		nxt.cnt        = cnt;
		nxt.led        = led;
		nxt.press_ev   = 1'b0;
		nxt.release_ev = 1'b0;
		if (!level) begin
			// pressed (active low); counter above a lowered limit holds
			if (cnt < limit) begin
				nxt.cnt = cnt_inc;
				if (cnt_inc == limit) begin
					nxt.press_ev = 1'b1;
					nxt.led      = ~led;
				end
			end
		end else if (cnt != '0) begin
			nxt.cnt = cnt_dec;
			if (cnt_dec == '0) begin
				nxt.release_ev = 1'b1;
			end
		end
	end

endmodule

// ===== hdl/key_matrix_debounce_toggle.sv =====
// The result beat is valid in the cycle after its row sample beat is accepted.
// Throughput: one row sample per cycle while no result is stalled; all keys of a column update in parallel.
// The single result register holds a stalled result; a new sample is taken in
// the cycle the held result leaves.
// Reset: column, debounce counters and LED bits clear, limit returns to 3.
// ---------------------------------------------------------------------------
// key_matrix_debounce_toggle
// Scans a key/LED matrix one column per beat with integrating debounce.
// ---------------------------------------------------------------------------
module key_matrix_debounce_toggle #(
	parameter int COLUMNS = 4,
	parameter int ROWS    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  kmd_pkg::cnt_t cfg_wr_data,
	kmd_in_if.sink        scan_in,
	kmd_out_if.source     scan_out
);
	import kmd_pkg::*;

	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

	cnt_t             limit_q;
	logic [COL_W-1:0] col_q;
	cnt_t             cnt_q [COLUMNS][ROWS];
	logic [ROWS-1:0]  led_q [COLUMNS];

	logic             out_vld_q;
	logic [COL_W-1:0] col_out_q;
	logic [ROWS-1:0]  led_out_q;
	logic [ROWS-1:0]  press_q;
	logic [ROWS-1:0]  release_q;

	kmd_cell_t        key_nxt [ROWS];
	logic [ROWS-1:0]  led_nxt;
	logic [ROWS-1:0]  press_v;
	logic [ROWS-1:0]  release_v;
	logic             accept;

	assign scan_in.ready = !out_vld_q || scan_out.ready;
	assign accept        = scan_in.valid && scan_in.ready;

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		kmd_cell u_cell (
			.level (scan_in.row_levels[r]),
			.cnt   (cnt_q[col_q][r]),
			.limit (limit_q),
			.led   (led_q[col_q][r]),
			.nxt   (key_nxt[r])
		);
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			led_nxt[r]   = key_nxt[r].led;
			press_v[r]   = key_nxt[r].press_ev;
			release_v[r] = key_nxt[r].release_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			col_q   <= '0;
			for (int c = 0; c < COLUMNS; c++) begin
				led_q[c] <= '0;
				for (int r = 0; r < ROWS; r++) begin
					cnt_q[c][r] <= '0;
				end
			end
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				for (int r = 0; r < ROWS; r++) begin
					cnt_q[col_q][r] <= key_nxt[r].cnt;
				end
				led_q[col_q] <= led_nxt;
				col_q        <= (col_q == COL_LAST) ? '0 : col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (scan_in.ready) begin
			out_vld_q <= scan_in.valid;
		end
	end

	// led_rows reports the column's LEDs before this beat's toggles
	always_ff @(posedge clk) begin
		if (accept) begin
			col_out_q <= col_q;
			led_out_q <= led_q[col_q];
			press_q   <= press_v;
			release_q <= release_v;
		end
	end

	assign scan_out.valid          = out_vld_q;
	assign scan_out.column         = col_out_q;
	assign scan_out.led_rows       = led_out_q;
	assign scan_out.press_events   = press_q;
	assign scan_out.release_events = release_q;

endmodule

// ===== hdl/kmd_checker.sv =====
// ---------------------------------------------------------------------------
// kmd_checker
// Port-level checks of the key matrix scanner, bound to the top level.
// ---------------------------------------------------------------------------
module kmd_checker #(
	parameter int COLUMNS = 4,
	parameter int ROWS    = 4
) (
	input logic                                           clk,
	input logic                                           arst_n,
	input logic                                           in_valid,
	input logic                                           in_ready,
	input logic                                           out_valid,
	input logic                                           out_ready,
	input logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] column,
	input logic [ROWS-1:0]                                led_rows,
	input logic [ROWS-1:0]                                press_events,
	input logic [ROWS-1:0]                                release_events
);
	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

	logic             seen_q;
	logic [COL_W-1:0] last_col_q;
	logic [COL_W-1:0] exp_col;
	logic             out_beat;

	assign out_beat = out_valid && out_ready;
	assign exp_col  = (last_col_q == COL_LAST) ? '0 : last_col_q + COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_col_q <= '0;
		end else if (out_beat) begin
			seen_q     <= 1'b1;
			last_col_q <= column;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column) && $stable(led_rows)
			&& $stable(press_events) && $stable(release_events))
		else $error("stalled result changed");

	// a key cannot reach the limit and zero in the same tick
	a_ev_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_events & release_events) == '0)
		else $error("press and release on same key");

	// every accepted sample gives a result next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result missing after accepted sample");

	// a held result blocks new samples
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("sample taken while result stalled");

	// results walk the columns in order and wrap
	a_col_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_q |-> column == exp_col)
		else $error("column out of sequence");

endmodule

bind key_matrix_debounce_toggle kmd_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_kmd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (scan_in.valid),
	.in_ready       (scan_in.ready),
	.out_valid      (scan_out.valid),
	.out_ready      (scan_out.ready),
	.column         (scan_out.column),
	.led_rows       (scan_out.led_rows),
	.press_events   (scan_out.press_events),
	.release_events (scan_out.release_events)
);
